// File: src/kwm_pkg.sv
// Shared types and state encoding for the k-way sorted merge block.
package kwm_pkg;

    // One input item: a value tagged with its list, plus the end-of-set mark
    typedef struct packed {
        logic [1:0]         list_number;
        logic signed [31:0] value;
        logic               final_item;
    } in_item_t;

    // One result item of the merged sequence
    typedef struct packed {
        logic signed [31:0] merged_value;
        logic [1:0]         source_list;
        logic               last_result;
        logic               overflow_seen;
    } out_item_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_PUSH
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic scan_clear;
        logic scan_run;
        logic push;
        logic clear_set;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic set_empty;
        logic scan_last;
        logic out_free;
        logic last_pending;
    } dp_stat_t;

endpackage

// File: src/k_way_sorted_merge_top.sv
// Load phase: one item per cycle; a final item starts the merge, no items taken meanwhile.
// Results follow the final item, one per head scan; the head scan reads one list head per
// cycle from the single-port list memory.
// Results wait in an output register; the next scan runs meanwhile, its push waits for it.
// Synchronous active-low reset clears fill counts, heads, drop flag and the controller;
// list memory contents are not cleared and are only used below the fill counts.
module k_way_sorted_merge_top
    import kwm_pkg::*;
#(
    parameter int LISTS = 4,
    parameter int DEPTH = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencing
    kwm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_final (s_data.final_item),
        .in_ready (s_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Storage and compare
    kwm_dpath #(
        .LISTS (LISTS),
        .DEPTH (DEPTH)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_item   (s_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_item  (m_data)
    );

endmodule

// File: src/kwm_ctrl.sv
// Controller state machine: load phase, merge scan sequencing and result hand-off.
module kwm_ctrl
    import kwm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    input  logic     in_final,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load = 1'b1;
                    if (in_final) begin
                        state_next = ST_START;
                    end
                end
            end
            ST_START: begin
                // an empty set gives no results
                if (stat.set_empty) begin
                    cmd.clear_set = 1'b1;
                    state_next    = ST_IDLE;
                end else begin
                    cmd.scan_clear = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan_run = 1'b1;
                if (stat.scan_last) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (stat.out_free) begin
                    cmd.push = 1'b1;
                    if (stat.last_pending) begin
                        cmd.clear_set = 1'b1;
                        state_next    = ST_IDLE;
                    end else begin
                        cmd.scan_clear = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: src/kwm_dpath.sv
// Datapath: list memory, fill and head counters, head scan compare and output register.
module kwm_dpath
    import kwm_pkg::*;
#(
    parameter int LISTS = 4,
    parameter int DEPTH = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  dp_cmd_t   cmd,
    output dp_stat_t  stat,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    localparam int LW = $clog2(LISTS);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);
    localparam int TW = $clog2(LISTS * DEPTH + 1);
    localparam int SW = $clog2(LISTS + 1);
    localparam int MD = LISTS * (2 ** IW);

    localparam logic [FW-1:0] DEPTH_F = FW'(DEPTH);
    localparam logic [SW-1:0] LISTS_S = SW'(LISTS);
    localparam logic [3:0]    LISTS_4 = 4'(LISTS);

    // list storage, one slot of 2**IW entries per list
    logic signed [31:0] mem [MD];

    logic [FW-1:0] fill_reg [LISTS];
    logic [FW-1:0] head_reg [LISTS];
    logic [TW-1:0] total_reg;
    logic          dropped_reg;

    logic [SW-1:0] step_cnt_reg;
    logic          rd_issue_reg;
    logic          rd_cand_reg;
    logic [LW-1:0] rd_list_reg;
    logic signed [31:0] rd_data_reg;

    logic          best_found_reg;
    logic [LW-1:0] best_list_reg;
    logic signed [31:0] best_val_reg;

    logic      out_valid_reg;
    out_item_t out_reg;

    // Load side decode
    logic [3:0]       ln_ext;
    logic [LW-1:0]    ld_list;
    logic             ld_in_range;
    logic             ld_store;
    logic [LW+IW-1:0] wr_addr;

    assign ln_ext      = {2'b00, in_item.list_number};
    assign ld_list     = ln_ext[LW-1:0];
    assign ld_in_range = ln_ext < LISTS_4;
    assign ld_store    = cmd.load && ld_in_range && (fill_reg[ld_list] < DEPTH_F);
    assign wr_addr     = {ld_list, fill_reg[ld_list][IW-1:0]};

    // Scan side: read the head of one list per cycle
    logic [LW-1:0]    scan_list;
    logic             scan_issue;
    logic [LW+IW-1:0] rd_addr;
    logic             take;
    logic [3:0]       best_ext;

    assign scan_list  = step_cnt_reg[LW-1:0];
    assign scan_issue = cmd.scan_run && (step_cnt_reg < LISTS_S);
    assign rd_addr    = {scan_list, head_reg[scan_list][IW-1:0]};
    assign take       = rd_issue_reg && rd_cand_reg &&
                        (!best_found_reg || (rd_data_reg < best_val_reg));
    assign best_ext   = 4'(best_list_reg);

    // Memory write and registered read
    always_ff @(posedge aclk) begin
        if (ld_store) begin
            mem[wr_addr] <= in_item.value;
        end
        if (scan_issue) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Payload registers: best candidate value and result item
    always_ff @(posedge aclk) begin
        if (take) begin
            best_val_reg <= rd_data_reg;
        end
        if (cmd.push) begin
            out_reg.merged_value  <= best_val_reg;
            out_reg.source_list   <= best_ext[1:0];
            out_reg.last_result   <= (total_reg == TW'(1));
            out_reg.overflow_seen <= dropped_reg;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LISTS; i++) begin
                fill_reg[i] <= '0;
                head_reg[i] <= '0;
            end
            total_reg      <= '0;
            dropped_reg    <= 1'b0;
            step_cnt_reg   <= '0;
            rd_issue_reg   <= 1'b0;
            rd_cand_reg    <= 1'b0;
            rd_list_reg    <= '0;
            best_found_reg <= 1'b0;
            best_list_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            // loading
            if (cmd.load && ld_in_range) begin
                if (ld_store) begin
                    fill_reg[ld_list] <= fill_reg[ld_list] + FW'(1);
                    total_reg         <= total_reg + TW'(1);
                end else begin
                    dropped_reg <= 1'b1;
                end
            end

            // scan sequencing
            rd_issue_reg <= scan_issue;
            if (scan_issue) begin
                rd_cand_reg  <= head_reg[scan_list] < fill_reg[scan_list];
                rd_list_reg  <= scan_list;
                step_cnt_reg <= step_cnt_reg + SW'(1);
            end
            if (take) begin
                best_found_reg <= 1'b1;
                best_list_reg  <= rd_list_reg;
            end
            if (cmd.scan_clear) begin
                step_cnt_reg   <= '0;
                best_found_reg <= 1'b0;
            end

            // result hand-off
            if (out_valid_reg && out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.push) begin
                out_valid_reg           <= 1'b1;
                head_reg[best_list_reg] <= head_reg[best_list_reg] + FW'(1);
                total_reg               <= total_reg - TW'(1);
            end

            // end of set: start afresh
            if (cmd.clear_set) begin
                for (int i = 0; i < LISTS; i++) begin
                    fill_reg[i] <= '0;
                    head_reg[i] <= '0;
                end
                total_reg   <= '0;
                dropped_reg <= 1'b0;
            end
        end
    end

    // Status to the controller
    assign stat.set_empty    = (total_reg == '0);
    assign stat.scan_last    = (step_cnt_reg == LISTS_S);
    assign stat.out_free     = !out_valid_reg || out_ready;
    assign stat.last_pending = (total_reg == TW'(1));

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

// File: src/kwm_checker.sv
// Port-level checks for the k-way sorted merge block, bound to the top level.
module kwm_checker
    import kwm_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed while stalled");

    // a non-final item never produces a result in the following cycle
    a_no_result_on_load: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_data.final_item |=> !$rose(m_valid))
        else $error("result appeared after a non-final item");

    // the merge starts after a final item: no item is taken next
    a_merge_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.final_item |=> !s_ready)
        else $error("input taken right after final item");

    // while a non-last result waits the merge is still running
    a_merge_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last_result |-> !s_ready)
        else $error("input ready in the middle of a merge");

endmodule

bind k_way_sorted_merge_top kwm_checker u_kwm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
